/* rtl/bap_pkg.sv */
// Shared types and constants of the advertising name and manufacturer parser.
`default_nettype none
package bap_pkg;

   localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
   localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;
   localparam logic [7:0] TYPE_MFG_DATA   = 8'hFF;
   localparam logic [7:0] CHAR_LOW        = 8'h20;
   localparam logic [7:0] CHAR_HIGH       = 8'h7E;
   localparam logic [6:0] CHAR_SUBST      = 7'h3F;
   localparam logic [5:0] CAP_RESET       = 6'd32;
   localparam int         SLOT_LIMIT      = 32;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_VALUE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BYTE,
      T_START,
      T_WAIT
   } top_state_type;

   typedef enum logic [1:0] {
      E_IDLE,
      E_READ,
      E_SHOW
   } emit_state_type;

   typedef struct packed {
      logic [4:0]  len;
      logic [15:0] company;
      logic        bank;
   } kept_type;

   function automatic logic is_name_type(input logic [7:0] t);
      return (t == TYPE_SHORT_NAME) || (t == TYPE_FULL_NAME);
   endfunction

   function automatic logic [6:0] sanitize(input logic [7:0] b);
      return ((b < CHAR_LOW) || (b > CHAR_HIGH)) ? CHAR_SUBST : b[6:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/bap_ifs.sv */
// Channel interfaces: payload byte requests, name results and the capacity register write.
`default_nettype none
interface bap_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] adv_byte;
   logic       last_byte;
   modport source(output valid, has_byte, adv_byte, last_byte, input ready);
   modport sink(input valid, has_byte, adv_byte, last_byte, output ready);
endinterface

interface bap_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  name_char;
   logic [4:0]  name_len;
   logic [15:0] company_id;
   logic        last_result;
   modport source(output valid, name_char, name_len, company_id, last_result, input ready);
   modport sink(input valid, name_char, name_len, company_id, last_result, output ready);
endinterface

interface bap_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] max_name_bytes;
   modport source(output valid, max_name_bytes, input ready);
   modport sink(input valid, max_name_bytes, output ready);
endinterface
`default_nettype wire

/* rtl/bap_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module bap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/bap_walker.sv */
// Length/type/value structure walker: tracks pending and kept name and company ID.
`default_nettype none
module bap_walker #(
   parameter int NAME_CAP = 32,
   localparam int SLOTS = (NAME_CAP < 32) ? NAME_CAP : 32,
   localparam int LEN_W = $clog2(SLOTS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_en,
   input  wire logic [7:0]        byte_in,
   input  wire logic              clear,
   input  wire logic [5:0]        max_name_bytes,
   output logic                   wr_en,
   output logic      [LEN_W:0]    wr_addr,
   output logic      [6:0]        wr_data,
   output bap_pkg::kept_type      kept
);
   import bap_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [7:0]       bytes_left_ff, bytes_left_in;
   logic [7:0]       type_ff, type_in;
   logic [LEN_W-1:0] pend_len_ff, pend_len_in;
   logic [15:0]      pend_comp_ff, pend_comp_in;
   logic [1:0]       vidx_ff, vidx_in;
   logic [LEN_W-1:0] kept_len_ff, kept_len_in;
   logic [15:0]      kept_comp_ff, kept_comp_in;
   logic             bank_ff, bank_in;
   logic [7:0]       left_dec;
   logic             finish;
   logic [5:0]       cap;
   logic [5:0]       cap_m1;
   logic [5:0]       pend_ext;

   assign left_dec = bytes_left_ff - 8'd1;
   assign cap      = (max_name_bytes > 6'(SLOTS)) ? 6'(SLOTS) : max_name_bytes;
   assign cap_m1   = cap - 6'd1;
   assign pend_ext = 6'(pend_len_in);

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      type_in       = type_ff;
      pend_len_in   = pend_len_ff;
      pend_comp_in  = pend_comp_ff;
      vidx_in       = vidx_ff;
      kept_len_in   = kept_len_ff;
      kept_comp_in  = kept_comp_ff;
      bank_in       = bank_ff;
      finish        = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = {~bank_ff, pend_len_ff};
      wr_data       = sanitize(byte_in);
      if (clear) begin
         phase_in      = PH_LEN;
         bytes_left_in = '0;
         type_in       = '0;
         pend_len_in   = '0;
         pend_comp_in  = '0;
         vidx_in       = '0;
         kept_len_in   = '0;
         kept_comp_in  = '0;
      end else if (byte_en) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (byte_in == 8'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  bytes_left_in = byte_in;
                  phase_in      = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in       = byte_in;
               pend_len_in   = '0;
               pend_comp_in  = '0;
               vidx_in       = '0;
               bytes_left_in = left_dec;
               if (left_dec == 8'd0) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (is_name_type(type_ff) && (pend_len_ff < LEN_W'(SLOTS - 1))) begin
                  wr_en       = 1'b1;
                  pend_len_in = pend_len_ff + 1'b1;
               end
               if (vidx_ff == 2'd0) begin
                  pend_comp_in = {8'd0, byte_in};
               end else if (vidx_ff == 2'd1) begin
                  pend_comp_in = {byte_in, pend_comp_ff[7:0]};
               end
               if (vidx_ff != 2'd2) begin
                  vidx_in = vidx_ff + 2'd1;
               end
               bytes_left_in = left_dec;
               finish        = (left_dec == 8'd0);
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
         if (finish) begin
            phase_in = PH_LEN;
            if (is_name_type(type_in)) begin
               if (cap != 6'd0) begin
                  kept_len_in = LEN_W'((pend_ext > cap_m1) ? cap_m1 : pend_ext);
                  bank_in     = ~bank_ff;
               end
            end else if ((type_in == TYPE_MFG_DATA) && (vidx_in == 2'd2)) begin
               kept_comp_in = pend_comp_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         bytes_left_ff <= '0;
         type_ff       <= '0;
         pend_len_ff   <= '0;
         pend_comp_ff  <= '0;
         vidx_ff       <= '0;
         kept_len_ff   <= '0;
         kept_comp_ff  <= '0;
         bank_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         type_ff       <= type_in;
         pend_len_ff   <= pend_len_in;
         pend_comp_ff  <= pend_comp_in;
         vidx_ff       <= vidx_in;
         kept_len_ff   <= kept_len_in;
         kept_comp_ff  <= kept_comp_in;
         bank_ff       <= bank_in;
      end
   end

   assign kept.len     = 5'(kept_len_ff);
   assign kept.company = kept_comp_ff;
   assign kept.bank    = bank_ff;
endmodule
`default_nettype wire

/* rtl/bap_emitter.sv */
// Name burst sequencer: reads kept characters from the name RAM and drives the result channel.
`default_nettype none
module bap_emitter #(
   parameter int NAME_CAP = 32,
   localparam int SLOTS = (NAME_CAP < 32) ? NAME_CAP : 32,
   localparam int LEN_W = $clog2(SLOTS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire bap_pkg::kept_type kept,
   input  wire logic [6:0]       rd_data,
   output logic                  rd_en,
   output logic      [LEN_W:0]   rd_addr,
   output logic                  busy,
   bap_rsp_if.source             rsp_if
);
   import bap_pkg::*;

   emit_state_type   state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [4:0]       len_ff;
   logic [15:0]      comp_ff;
   logic             bank_ff;
   logic             empty;
   logic             at_end;

   assign empty  = (len_ff == 5'd0);
   assign at_end = empty || (5'(idx_ff) == (len_ff - 5'd1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               idx_in   = '0;
               state_in = (kept.len == 5'd0) ? E_SHOW : E_READ;
            end
         end
         E_READ: begin
            state_in = E_SHOW;
         end
         E_SHOW: begin
            if (rsp_if.ready) begin
               if (at_end) begin
                  state_in = E_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = E_READ;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_en              = (state_ff == E_READ);
      rd_addr            = {bank_ff, idx_ff};
      busy               = (state_ff != E_IDLE);
      rsp_if.valid       = (state_ff == E_SHOW);
      rsp_if.name_char   = empty ? 7'd0 : rd_data;
      rsp_if.name_len    = len_ff;
      rsp_if.company_id  = comp_ff;
      rsp_if.last_result = at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == E_IDLE) && start) begin
         len_ff  <= kept.len;
         comp_ff <= kept.company;
         bank_ff <= kept.bank;
      end
   end
endmodule
`default_nettype wire

/* rtl/ble_adv_name_mfg_parser.sv */
// Top level of the advertising payload parser: name and manufacturer company ID extraction.
//
// req_if carries one payload byte per item (has_byte, adv_byte, last_byte). Each item
// is accepted in T_IDLE and then stepped by the structure walker in T_BYTE; req_if.ready
// is high only in T_IDLE, so a new item is not taken until the last one is walked.
// An item with last_byte set starts the name burst once its byte is walked: one result
// per kept character on rsp_if (one result with name_char 0 for an empty name), each
// result first read from the name RAM and then shown, last_result on the final one.
// req_if stays not ready until the burst is fully taken; a stall on rsp_if holds the
// current result and the burst.
// csr_if writes max_name_bytes (always ready); write it only while the block is idle.
// Reset clears the walker to await a length byte, empties name and ID, and sets the
// capacity to 32. Name storage is two banks of a RAM that are swapped on a completed
// name structure while the capacity is nonzero; no clearing pass is needed.
`default_nettype none
module ble_adv_name_mfg_parser #(
   parameter int NAME_CAP = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   bap_req_if.sink   req_if,
   bap_rsp_if.source rsp_if,
   bap_csr_if.sink   csr_if
);
   import bap_pkg::*;

   localparam int SLOTS = (NAME_CAP < SLOT_LIMIT) ? NAME_CAP : SLOT_LIMIT;
   localparam int LEN_W = $clog2(SLOTS);

   top_state_type state_ff, state_in;
   logic          has_ff;
   logic [7:0]    byte_ff;
   logic          last_ff;
   logic [5:0]    cap_ff;
   logic          accept;
   logic          byte_en;
   logic          start;
   logic          busy;
   logic          wr_en;
   logic [LEN_W:0] wr_addr;
   logic [6:0]    wr_data;
   logic          rd_en;
   logic [LEN_W:0] rd_addr;
   logic [6:0]    rd_data;
   kept_type      kept_s;

   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_BYTE;
            end
         end
         T_BYTE: begin
            state_in = last_ff ? T_START : T_IDLE;
         end
         T_START: begin
            state_in = T_WAIT;
         end
         T_WAIT: begin
            if (!busy) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == T_IDLE);
      byte_en      = (state_ff == T_BYTE) && has_ff;
      start        = (state_ff == T_START);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid) begin
            cap_ff <= csr_if.max_name_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         has_ff  <= req_if.has_byte;
         byte_ff <= req_if.adv_byte;
         last_ff <= req_if.last_byte;
      end
   end

   bap_walker #(.NAME_CAP(NAME_CAP)) u_walker (
      .clock          (clock),
      .reset          (reset),
      .byte_en        (byte_en),
      .byte_in        (byte_ff),
      .clear          (start),
      .max_name_bytes (cap_ff),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .kept           (kept_s)
   );

   bap_ram #(.WIDTH(7), .DEPTH(2 << LEN_W)) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bap_emitter #(.NAME_CAP(NAME_CAP)) u_emitter (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .kept    (kept_s),
      .rd_data (rd_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .busy    (busy),
      .rsp_if  (rsp_if)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_if.valid && req_if.ready))
      else $error("result shown while accepting a byte");

   a_empty_name: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.name_len == 5'd0)) |->
         (rsp_if.last_result && (rsp_if.name_char == 7'd0)))
      else $error("empty name result malformed");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_result) |=> !rsp_if.valid)
      else $error("result after final item of burst");

   a_kept_len: assert property (@(posedge clock) disable iff (reset)
      kept_s.len <= 5'(SLOTS - 1))
      else $error("kept name length beyond capacity");
endmodule
`default_nettype wire
